/* hdl/salc_pkg.sv */
// Shared types, constants and the arctangent table for the segment classifier.
package salc_pkg;

	localparam int IN_W     = 12;   // width of one endpoint coordinate field
	localparam int ANG_W    = 15;
	localparam int LEN_W    = 17;
	localparam int THR_W    = 13;
	localparam int T_W      = 13;   // first-quadrant angle, 0..5760
	localparam int ZW       = 25;   // angle accumulator, degrees * 2^16, signed
	localparam int ANG_FRAC = 16;
	localparam int ATAN_LEN = 24;

	localparam logic [THR_W-1:0] THR_RESET = 13'd640;
	localparam logic [T_W-1:0]   T_90      = 13'd5760;
	localparam logic [ANG_W-1:0] ANG_90    = 15'd5760;
	localparam logic [ANG_W-1:0] ANG_180   = 15'd11520;
	localparam logic [LEN_W-1:0] LEN_MAX   = 17'h1FFFF;

	// Segment class decided up front and carried along the chain.
	typedef struct packed {
		logic zero_vec;  // both endpoints equal
		logic vert;      // dx zero, dy nonzero
		logic horiz;     // dy zero, dx nonzero
		logic dx_neg;    // end lies left of start
	} salc_case_t;

	// atan(2^-i) in degrees * 65536, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
		logic signed [ZW-1:0] v;
		unique case (i)
			0:  v = 25'sd2949120;
			1:  v = 25'sd1740967;
			2:  v = 25'sd919879;
			3:  v = 25'sd466945;
			4:  v = 25'sd234379;
			5:  v = 25'sd117304;
			6:  v = 25'sd58666;
			7:  v = 25'sd29335;
			8:  v = 25'sd14668;
			9:  v = 25'sd7334;
			10: v = 25'sd3667;
			11: v = 25'sd1833;
			12: v = 25'sd917;
			13: v = 25'sd458;
			14: v = 25'sd229;
			15: v = 25'sd115;
			16: v = 25'sd57;
			17: v = 25'sd29;
			18: v = 25'sd14;
			19: v = 25'sd7;
			20: v = 25'sd4;
			21: v = 25'sd2;
			22: v = 25'sd1;
			default: v = 25'sd0;
		endcase
		return v;
	endfunction

endpackage

/* hdl/salc_if.sv */
// Valid/ready channel interfaces for segment items and result items.
interface salc_seg_if import salc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IN_W-1:0]  x_first;
	logic [IN_W-1:0]  y_first;
	logic [IN_W-1:0]  x_second;
	logic [IN_W-1:0]  y_second;

	modport source (output valid, x_first, y_first, x_second, y_second, input ready);
	modport sink   (input valid, x_first, y_first, x_second, y_second, output ready);
endinterface

interface salc_res_if import salc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ANG_W-1:0] angle;
	logic [LEN_W-1:0] length;
	logic             near_vertical;

	modport source (output valid, angle, length, near_vertical, input ready);
	modport sink   (input valid, angle, length, near_vertical, output ready);
endinterface

/* hdl/salc_cell.sv */
// One chain cell: a CORDIC vectoring step and a square-root digit step, each enabled by a parameter.
module salc_cell import salc_pkg::*; #(
	parameter int IDX       = 0,
	parameter int XW        = 31,
	parameter int SW        = 34,
	parameter int RB        = 17,
	parameter bit CORDIC_ON = 1'b1,
	parameter bit SQRT_ON   = 1'b1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 v_in,
	input  salc_case_t           case_in,
	input  logic signed [XW-1:0] x_in,
	input  logic signed [XW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	input  logic [SW-1:0]        r_in,
	input  logic [SW-1:0]        rem_in,
	output logic                 v_out,
	output salc_case_t           case_out,
	output logic signed [XW-1:0] x_out,
	output logic signed [XW-1:0] y_out,
	output logic signed [ZW-1:0] z_out,
	output logic [SW-1:0]        r_out,
	output logic [SW-1:0]        rem_out
);

	localparam int SH = SQRT_ON ? 2 * (RB - 1 - IDX) : 0;
	localparam logic [SW-1:0] BIT_C = SW'(1) << SH;
	localparam logic signed [ZW-1:0] ATAN_C = atan_entry(IDX);

	logic signed [XW-1:0] xs, ys, x_d, y_d;
	logic signed [ZW-1:0] z_d;
	logic [SW-1:0]        trial, r_d, rem_d;

	always_comb begin
		xs = x_in >>> IDX;
		ys = y_in >>> IDX;
		x_d = x_in;
		y_d = y_in;
		z_d = z_in;
		if (CORDIC_ON) begin
			// rotate toward the x axis
			if (y_in > 0) begin
				x_d = x_in + ys;
				y_d = y_in - xs;
				z_d = z_in + ATAN_C;
			end else begin
				x_d = x_in - ys;
				y_d = y_in + xs;
				z_d = z_in - ATAN_C;
			end
		end
	end

	always_comb begin
		trial = r_in + BIT_C;
		r_d = r_in;
		rem_d = rem_in;
		if (SQRT_ON) begin
			if (rem_in >= trial) begin
				rem_d = rem_in - trial;
				r_d = (r_in >> 1) + BIT_C;
			end else begin
				r_d = r_in >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (adv) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case_out <= case_in;
			x_out <= x_d;
			y_out <= y_d;
			z_out <= z_d;
			r_out <= r_d;
			rem_out <= rem_d;
		end
	end

endmodule

/* hdl/salc_finish.sv */
// Tail stages: angle rounding and quadrant mapping, length rounding, vertical flag.
module salc_finish import salc_pkg::*; #(
	parameter int SW = 34
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 v_in,
	input  salc_case_t           case_in,
	input  logic signed [ZW-1:0] z_in,
	input  logic [SW-1:0]        r_in,
	input  logic [SW-1:0]        rem_in,
	input  logic [THR_W-1:0]     thr,
	output logic                 v_out,
	output logic [ANG_W-1:0]     angle_s2,
	output logic [LEN_W-1:0]     length_s2,
	output logic                 near_vertical_s2
);

	logic signed [ZW-1:0] zr;
	logic [T_W-1:0]       t_d;
	logic [SW-1:0]        lr;
	logic [LEN_W-1:0]     len_d;

	logic                 v_s1;
	salc_case_t           case_s1;
	logic [T_W-1:0]       t_s1;
	logic [LEN_W-1:0]     len_s1;

	logic                 general;
	logic [T_W-1:0]       t_eff;
	logic [T_W-1:0]       dev;
	logic [ANG_W-1:0]     ang_d;
	logic                 is180;

	// round to 1/64 degree, clamp to the first quadrant; round the root to nearest
	always_comb begin
		zr = (z_in + ZW'(512)) >>> 10;
		if (zr < 0) begin
			t_d = '0;
		end else if (zr > ZW'(T_90)) begin
			t_d = T_90;
		end else begin
			t_d = zr[T_W-1:0];
		end
		lr = r_in + SW'(rem_in > r_in);
		len_d = (lr > SW'(LEN_MAX)) ? LEN_MAX : lr[LEN_W-1:0];
	end

	// deviation from vertical is 90 - t in every case the segment can take
	always_comb begin
		general = !(case_s1.zero_vec || case_s1.vert || case_s1.horiz);
		if (case_s1.vert) begin
			t_eff = T_90;
		end else if (general) begin
			t_eff = t_s1;
		end else begin
			t_eff = '0;
		end
		if (general && case_s1.dx_neg) begin
			ang_d = ANG_180 - ANG_W'(t_eff);
		end else begin
			ang_d = ANG_W'(t_eff);
		end
		is180 = general && case_s1.dx_neg && (t_s1 == '0);
		dev = T_90 - t_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_out <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_out <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case_s1 <= case_in;
			t_s1 <= t_d;
			len_s1 <= len_d;
			angle_s2 <= ang_d;
			length_s2 <= len_s1;
			near_vertical_s2 <= !is180 && (dev < thr);
		end
	end

endmodule

/* hdl/segment_angle_length_classify.sv */
// Top level: segment direction, length and near-vertical classification pipeline.
//
//  channel  dir  handshake            payload
//  seg      in   valid/ready          x_first, y_first, x_second, y_second
//  res      out  valid/ready          angle, length, near_vertical
//  cfg      in   cfg_we (no ready)    cfg_wdata = angle_threshold
//
// One item enters per cycle while the chain is not held. Registers in order: front,
// square, one chain cell per CORDIC step or root digit (whichever count is larger sets
// the chain), then rounding and the output register.
// Reset clears every valid bit and loads the threshold with 640.
// The chain moves as a whole: it holds only while a result sits in the output
// register and res.ready is low; seg.ready drops in exactly those cycles.
module segment_angle_length_classify import salc_pkg::*; #(
	parameter int COORD_BITS    = 12,
	parameter int CORDIC_STAGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [THR_W-1:0]  cfg_wdata,
	salc_seg_if.sink          seg,
	salc_res_if.source        res
);

	localparam int CB = COORD_BITS;
	localparam int CW = (CB > IN_W) ? CB : IN_W;
	localparam int XW = CB + 19;          // CORDIC x/y, coordinates * 2^16 with gain
	localparam int NW = 2 * CB + 9;       // 256 * (dx^2 + dy^2)
	localparam int SW = NW + 1;           // root and remainder in the digit cells
	localparam int RB = CB + 5;           // result bits of the root
	localparam int NC = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
	localparam int L  = (NC > RB) ? NC : RB;

	logic adv;
	logic v_out;
	logic [THR_W-1:0] thr_q;

	// Threshold register; the user must write it only while the pipeline is empty, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Advance everything unless a finished result is waiting.
	assign adv = !v_out || res.ready;
	assign seg.ready = adv;

	// ---- front stage: mask coordinates, pick the start point, form the vector
	logic [CW-1:0] x1w, y1w, x2w, y2w;
	logic [CB-1:0] x1, y1, x2, y2, xs, ys, xe, ye;
	logic signed [CB:0] dx, dy;
	logic [CB-1:0] ax_d, ay_d;
	salc_case_t case_d;

	always_comb begin
		x1w = CW'(seg.x_first);
		y1w = CW'(seg.y_first);
		x2w = CW'(seg.x_second);
		y2w = CW'(seg.y_second);
		x1 = x1w[CB-1:0];
		y1 = y1w[CB-1:0];
		x2 = x2w[CB-1:0];
		y2 = y2w[CB-1:0];
		// start has the greater y; a tie takes the second endpoint
		if (y1 > y2) begin
			xs = x1; ys = y1; xe = x2; ye = y2;
		end else begin
			xs = x2; ys = y2; xe = x1; ye = y1;
		end
		dx = $signed({1'b0, xe}) - $signed({1'b0, xs});
		dy = $signed({1'b0, ye}) - $signed({1'b0, ys});
		ax_d = dx[CB] ? CB'(-dx) : dx[CB-1:0];
		ay_d = dy[CB] ? CB'(-dy) : dy[CB-1:0];
		// dy never goes positive, so only the sign of dx picks the quadrant
		case_d.zero_vec = (dx == '0) && (dy == '0);
		case_d.vert     = (dx == '0) && (dy != '0);
		case_d.horiz    = (dy == '0) && (dx != '0);
		case_d.dx_neg   = dx[CB];
	end

	logic          v_s1, v_s2;
	salc_case_t    case_s1, case_s2;
	logic [CB-1:0] ax_s1, ay_s1, ax_s2, ay_s2;
	logic [NW-1:0] n_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= seg.valid;
			v_s2 <= v_s1;
		end
	end

	// ---- square stage: 256 * (ax^2 + ay^2) for the root chain
	always_ff @(posedge clk) begin
		if (adv) begin
			case_s1 <= case_d;
			ax_s1 <= ax_d;
			ay_s1 <= ay_d;
			case_s2 <= case_s1;
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			n_s2 <= NW'((2 * CB + 1)'(ax_s1 * ax_s1) + (2 * CB + 1)'(ay_s1 * ay_s1)) << 8;
		end
	end

	// ---- cell chain
	logic                 cv    [0:L];
	salc_case_t           ccase [0:L];
	logic signed [XW-1:0] cx    [0:L];
	logic signed [XW-1:0] cy    [0:L];
	logic signed [ZW-1:0] cz    [0:L];
	logic [SW-1:0]        cr    [0:L];
	logic [SW-1:0]        crem  [0:L];

	assign cv[0]    = v_s2;
	assign ccase[0] = case_s2;
	assign cx[0]    = $signed(XW'(ax_s2) << ANG_FRAC);
	assign cy[0]    = $signed(XW'(ay_s2) << ANG_FRAC);
	assign cz[0]    = '0;
	assign cr[0]    = '0;
	assign crem[0]  = SW'(n_s2);

	for (genvar i = 0; i < L; i++) begin : g_cell
		salc_cell #(
			.IDX       (i),
			.XW        (XW),
			.SW        (SW),
			.RB        (RB),
			.CORDIC_ON (i < NC),
			.SQRT_ON   (i < RB)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.v_in     (cv[i]),
			.case_in  (ccase[i]),
			.x_in     (cx[i]),
			.y_in     (cy[i]),
			.z_in     (cz[i]),
			.r_in     (cr[i]),
			.rem_in   (crem[i]),
			.v_out    (cv[i+1]),
			.case_out (ccase[i+1]),
			.x_out    (cx[i+1]),
			.y_out    (cy[i+1]),
			.z_out    (cz[i+1]),
			.r_out    (cr[i+1]),
			.rem_out  (crem[i+1])
		);
	end

	// ---- rounding, quadrant mapping and the output register
	salc_finish #(
		.SW (SW)
	) u_finish (
		.clk              (clk),
		.arst_n           (arst_n),
		.adv              (adv),
		.v_in             (cv[L]),
		.case_in          (ccase[L]),
		.z_in             (cz[L]),
		.r_in             (cr[L]),
		.rem_in           (crem[L]),
		.thr              (thr_q),
		.v_out            (v_out),
		.angle_s2         (res.angle),
		.length_s2        (res.length),
		.near_vertical_s2 (res.near_vertical)
	);

	assign res.valid = v_out;

	// ---- checks
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |-> !seg.ready)
		else $error("input taken while a result is stalled");

	a_angle_upper_half: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.angle <= ANG_180))
		else $error("angle beyond 180 degrees");

	a_flag_not_at_180: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.near_vertical) |-> (res.angle != ANG_180))
		else $error("near_vertical set at 180 degrees");

	a_zero_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (thr_q == '0)) |-> !res.near_vertical)
		else $error("near_vertical set with zero threshold");

	a_vertical_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.angle == ANG_90) && (thr_q != '0)) |-> res.near_vertical)
		else $error("exact vertical not flagged");

endmodule

/* sim/salc_result_checker.sv */
// Checker for the segment classifier: predicts each result item and compares it field by field.
module salc_result_checker import salc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata,
	salc_seg_if              seg,
	salc_res_if              res,
	output int               mismatches,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ANG_W-1:0] angle;
		logic [LEN_W-1:0] length;
		logic             near_vertical;
	} seg_result_t;

	localparam int     CORDIC_STEPS = 16;
	localparam longint DEG_90       = 5760;
	localparam longint DEG_180      = 11520;
	localparam longint DEG_270      = 17280;
	localparam longint DEG_360      = 23040;
	localparam longint LEN_LIMIT    = 131071;

	// atan(2^-i) in degrees scaled by 2^16
	localparam longint ATAN_STEP [CORDIC_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	logic [THR_W-1:0] threshold;
	seg_result_t      expected_results [$];
	int               results_seen;

	function automatic seg_result_t classify_segment(
		input logic [IN_W-1:0]  xa,
		input logic [IN_W-1:0]  ya,
		input logic [IN_W-1:0]  xb,
		input logic [IN_W-1:0]  yb,
		input logic [THR_W-1:0] thr
	);
		seg_result_t r;
		longint dx, dy, ax, ay;
		longint cx, cy, cz, sx, sy, t, ang;
		longint sq, rest, root, digit, ref_ang, dev;
		// the endpoint with the greater y starts the segment, the second one on a tie
		if (ya > yb) begin
			dx = longint'(xb) - longint'(xa);
			dy = longint'(yb) - longint'(ya);
		end else begin
			dx = longint'(xa) - longint'(xb);
			dy = longint'(ya) - longint'(yb);
		end
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;

		if (dx == 0 && dy == 0) begin
			ang = 0;
		end else if (dx == 0) begin
			ang = DEG_90;
		end else if (dy == 0) begin
			ang = 0;
		end else begin
			cx = ax <<< 16;
			cy = ay <<< 16;
			cz = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				sx = cx >>> i;
				sy = cy >>> i;
				if (cy > 0) begin
					cx = cx + sy;
					cy = cy - sx;
					cz = cz + ATAN_STEP[i];
				end else begin
					cx = cx - sy;
					cy = cy + sx;
					cz = cz - ATAN_STEP[i];
				end
			end
			t = (cz + 512) >>> 10;
			if (t < 0)
				t = 0;
			if (t > DEG_90)
				t = DEG_90;
			if (dx > 0 && dy < 0)
				ang = t;
			else if (dx < 0 && dy < 0)
				ang = DEG_180 - t;
			else if (dx < 0)
				ang = DEG_180 + t;
			else
				ang = (t == 0) ? 0 : DEG_360 - t;
		end

		// digit-by-digit root of 256*(dx^2+dy^2), then round to nearest
		sq   = (ax * ax + ay * ay) * 256;
		rest = sq;
		root = 0;
		for (int k = 34; k >= 0; k -= 2) begin
			digit = longint'(1) << k;
			if (rest >= root + digit) begin
				rest = rest - (root + digit);
				root = (root >> 1) + digit;
			end else begin
				root = root >> 1;
			end
		end
		if (sq - root * root > root)
			root++;
		if (root > LEN_LIMIT)
			root = LEN_LIMIT;

		if (ang == DEG_180) begin
			r.near_vertical = 1'b0;
		end else begin
			ref_ang = (ang < DEG_180) ? DEG_90 : DEG_270;
			dev = (ang >= ref_ang) ? ang - ref_ang : ref_ang - ang;
			r.near_vertical = (dev < longint'(thr));
		end
		r.angle  = ang[ANG_W-1:0];
		r.length = root[LEN_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH result %0d at %0t: %s", results_seen, $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		seg_result_t want;
		if (!arst_n) begin
			threshold <= THR_RESET;
			expected_results.delete();
			pending <= 0;
			mismatches = 0;
			results_seen = 0;
		end else begin
			if (cfg_we)
				threshold <= cfg_wdata;
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result angle=%0d length=%0d nv=%0b",
						res.angle, res.length, res.near_vertical));
				end else begin
					want = expected_results.pop_front();
					if (res.angle !== want.angle)
						report_mismatch($sformatf("angle %0d, expected %0d",
							res.angle, want.angle));
					if (res.length !== want.length)
						report_mismatch($sformatf("length %0d, expected %0d",
							res.length, want.length));
					if (res.near_vertical !== want.near_vertical)
						report_mismatch($sformatf("near_vertical %0b, expected %0b",
							res.near_vertical, want.near_vertical));
				end
				results_seen++;
			end
			if (seg.valid && seg.ready)
				expected_results.push_back(classify_segment(seg.x_first, seg.y_first,
					seg.x_second, seg.y_second, threshold));
			pending <= expected_results.size();
		end
	end

endmodule

/* sim/testbench.sv */
// Top of the segment classifier testbench: clock, reset, stimulus, back-pressure and verdict.
module testbench import salc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// pipeline depth of the block at the default parameters
	localparam int LATENCY     = 21;
	localparam int PHASE_ITEMS = 238;
	localparam int LONG_HOLD   = 300;
	localparam int LIMIT       = 400000;
	localparam int COORD_MAX   = (1 << IN_W) - 1;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [THR_W-1:0] cfg_wdata;

	salc_seg_if seg_ch ();
	salc_res_if res_ch ();

	int mismatches;
	int pending;
	int cycle_count = 0;
	int hold_requests = 0;
	logic sender_steady = 1'b0;

	segment_angle_length_classify i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.seg       (seg_ch),
		.res       (res_ch)
	);

	salc_result_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.seg        (seg_ch),
		.res        (res_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#6ns clk = 1'b1;
		#6ns clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("Some tests failed");
			$finish;
		end
	end

	// Clamp a coordinate into the field range.
	function automatic logic [IN_W-1:0] pin_coord(input int v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return IN_W'(COORD_MAX);
		return IN_W'(v);
	endfunction

	function automatic logic [IN_W-1:0] edge_coord();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return IN_W'(1);
			2:       return IN_W'(COORD_MAX - 1);
			3:       return IN_W'(COORD_MAX);
			4:       return IN_W'(1 << (IN_W - 1));
			default: return IN_W'((1 << (IN_W - 1)) - 1);
		endcase
	endfunction

	// Offer one segment item and hold it until the block takes it. The gap before
	// it is drawn per item; now and then flip between gapless runs and random gaps.
	task automatic send_segment(input logic [IN_W-1:0] xa, ya, xb, yb);
		int unsigned gap;
		if ($urandom_range(0, 31) == 0)
			sender_steady = !sender_steady;
		gap = sender_steady ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			seg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg_ch.x_first  <= xa;
		seg_ch.y_first  <= ya;
		seg_ch.x_second <= xb;
		seg_ch.y_second <= yb;
		seg_ch.valid    <= 1'b1;
		do @(posedge clk); while (!seg_ch.ready);
	endtask

	// Draw one random segment. Five in twelve are plain random endpoints; the rest aim at
	// the corners of the behavior: steep and flat segments, tiny ones, ties in y,
	// coincident endpoints and coordinates at the edges of the field.
	task automatic send_random_segment();
		int xa, ya, xb, yb, span;
		xa = $urandom_range(0, COORD_MAX);
		ya = $urandom_range(0, COORD_MAX);
		xb = $urandom_range(0, COORD_MAX);
		yb = $urandom_range(0, COORD_MAX);
		case ($urandom_range(0, 11))
			4:  xb = xa + int'($urandom_range(0, 80)) - 40;      // near vertical
			5:  yb = ya + int'($urandom_range(0, 80)) - 40;      // near horizontal
			6: begin                                             // very short
				xb = xa + int'($urandom_range(0, 16)) - 8;
				yb = ya + int'($urandom_range(0, 16)) - 8;
			end
			7: begin                                             // tie in y, maybe one point
				yb = ya;
				if ($urandom_range(0, 1) == 0)
					xb = xa;
			end
			8: begin
				xa = edge_coord();
				ya = edge_coord();
				xb = edge_coord();
				yb = edge_coord();
			end
			9, 10: begin                                         // sweep across the threshold
				span = (ya > yb) ? ya - yb : yb - ya;
				xb = xa + int'($urandom_range(0, span)) - span / 2;
			end
			default: ;
		endcase
		send_segment(pin_coord(xa), pin_coord(ya), pin_coord(xb), pin_coord(yb));
	endtask

	// Drop valid, then wait until every result is back plus the pipeline depth.
	task automatic drain();
		seg_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] value);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Receiver: draw a stall per result, with gapless runs mixed in. When the
	// sender asks for it, hold ready low for a long stretch so the pipeline
	// fills up and the block has to stall its input.
	initial begin
		int unsigned pause;
		int holds_done;
		logic steady;
		holds_done = 0;
		steady = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_requests != holds_done) begin
				holds_done++;
				pause = LONG_HOLD;
			end else begin
				if ($urandom_range(0, 31) == 0)
					steady = !steady;
				pause = steady ? 0 : $urandom_range(0, 16);
			end
			if (pause != 0) begin
				res_ch.ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	initial begin
		logic [THR_W-1:0] settings [8];
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		seg_ch.valid    <= 1'b0;
		seg_ch.x_first  <= '0;
		seg_ch.y_first  <= '0;
		seg_ch.x_second <= '0;
		seg_ch.y_second <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset threshold of 640.
		send_segment(12'd0, 12'd0, 12'd0, 12'd0);                // zero vector
		send_segment(12'd4095, 12'd4095, 12'd4095, 12'd4095);    // zero vector at the top
		send_segment(12'd100, 12'd50, 12'd100, 12'd3000);        // vertical, start is second
		send_segment(12'd0, 12'd4095, 12'd0, 12'd0);             // vertical, full height
		send_segment(12'd0, 12'd200, 12'd4095, 12'd200);         // horizontal, tie picks second
		send_segment(12'd4095, 12'd7, 12'd0, 12'd7);             // horizontal, pointing right
		send_segment(12'd0, 12'd4095, 12'd4095, 12'd0);          // 45 degrees
		send_segment(12'd4095, 12'd4095, 12'd0, 12'd0);          // 135 degrees
		send_segment(12'd0, 12'd0, 12'd4095, 12'd4095);          // 135 degrees, swapped ends
		send_segment(12'd4095, 12'd0, 12'd0, 12'd4095);          // 45 degrees, swapped ends
		send_segment(12'd0, 12'd4094, 12'd4095, 12'd4095);       // just short of 180
		send_segment(12'd4095, 12'd4095, 12'd0, 12'd4094);       // just short of 180
		send_segment(12'd0, 12'd4095, 12'd4095, 12'd4094);       // just above 0
		send_segment(12'd2000, 12'd4095, 12'd2001, 12'd0);       // steepest right of vertical
		send_segment(12'd2001, 12'd4095, 12'd2000, 12'd0);       // steepest left of vertical
		send_segment(12'd1, 12'd2, 12'd2, 12'd1);                // one-pixel diagonal
		send_segment(12'd5, 12'd5, 12'd6, 12'd5);                // unit length
		send_segment(12'd2048, 12'd2048, 12'd2047, 12'd2049);    // mid-field, tiny
		send_segment(12'd3000, 12'd1000, 12'd3100, 12'd200);
		send_segment(12'hAAA, 12'h555, 12'h555, 12'hAAA);
		send_segment(12'h555, 12'hAAA, 12'hAAA, 12'h555);
		send_segment(12'd1000, 12'd2000, 12'd824, 12'd1000);     // about 100 deg, edge of window
		send_segment(12'd1000, 12'd2000, 12'd1176, 12'd1000);    // about 80 deg, edge of window
		drain();

		// Random phases, each under its own threshold: both extremes, the all-ones and
		// zero patterns of the register, one, the reset value and three random values.
		settings[0] = '0;
		settings[1] = THR_W'(5760);
		settings[2] = '1;
		settings[3] = THR_W'(1);
		settings[4] = THR_W'($urandom_range(0, (1 << THR_W) - 1));
		settings[5] = THR_W'($urandom_range(1, 5760));
		settings[6] = THR_RESET;
		settings[7] = THR_W'($urandom_range(0, (1 << THR_W) - 1));
		foreach (settings[p]) begin
			write_threshold(settings[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// ask the receiver for a long hold while items keep coming
				if ((p == 1 || p == 5) && n == 60)
					hold_requests <= hold_requests + 1;
				send_random_segment();
			end
			// pause the sender until every result is back before the next write
			drain();
		end

		repeat (LATENCY) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
hdl/salc_pkg.sv
hdl/salc_if.sv
hdl/salc_cell.sv
hdl/salc_finish.sv
hdl/segment_angle_length_classify.sv
sim/salc_result_checker.sv
sim/testbench.sv
